// ===== src/sbi_pkg.sv =====
// ----------------------------------------------------------------------------
// Stage bracket interpolator package
// Shared types, constants and control structures for the stage bracket
// interpolator and its sub-modules.
// ----------------------------------------------------------------------------
package sbi_pkg;

  // Fixed field widths of the payload.
  localparam int TIME_BITS        = 48;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int FILE_BITS        = 16;
  localparam int INDEX_BITS       = 6;
  localparam int COUNT_BITS       = 7;
  localparam int DIV_CNT_W        = $clog2(WEIGHT_FRAC_BITS);

  // Default table depth handed to the top-level parameter.
  localparam int STAGE_DEPTH_DEF = 64;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic            REG_INTERP_EN   = 1'b0;
  localparam logic            REG_STAGE_COUNT = 1'b1;
  localparam logic                  INTERP_EN_RST   = 1'b1;
  localparam logic [COUNT_BITS-1:0] STAGE_COUNT_RST = 7'd1;

  // Item operations.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Cache slot actions.
  localparam logic [1:0] LACT_KEEP    = 2'd0;
  localparam logic [1:0] LACT_LOAD    = 2'd1;
  localparam logic [1:0] LACT_SWAP    = 2'd2;
  localparam logic [1:0] UACT_KEEP    = 2'd0;
  localparam logic [1:0] UACT_LOAD    = 2'd1;
  localparam logic [1:0] UACT_RELEASE = 2'd2;

  typedef struct packed {
    logic                  opcode;
    logic [INDEX_BITS-1:0] entry_index;
    logic [TIME_BITS-1:0]  time_value;
    logic [FILE_BITS-1:0]  file_id;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]     lower_stage;
    logic [INDEX_BITS-1:0]     upper_stage;
    logic [WEIGHT_FRAC_BITS:0] weight;
    logic [1:0]                lower_action;
    logic [1:0]                upper_action;
    logic [FILE_BITS-1:0]      lower_file;
    logic [FILE_BITS-1:0]      upper_file;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic rd_first;
    logic scan_step;
    logic take;
    logic div_step;
    logic result_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_query;
    logic hit;
    logic at_last;
    logic need_div;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== src/sbi_regs.sv =====
// ----------------------------------------------------------------------------
// Stage bracket interpolator configuration registers
// APB-style register file holding the interpolation enable and stage count.
// ----------------------------------------------------------------------------
module sbi_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sbi_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sbi_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sbi_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic                             interp_en,
  output logic [sbi_pkg::COUNT_BITS-1:0]   stage_count
);
  import sbi_pkg::*;

  logic                  interp_en_r;
  logic [COUNT_BITS-1:0] stage_count_r;
  logic                  wr_en;

  // Registers sit on word addresses, so only the word-select bit decodes.
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_en_r   <= INTERP_EN_RST;
      stage_count_r <= STAGE_COUNT_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_INTERP_EN) begin
        interp_en_r <= pwdata[0];
      end else begin
        stage_count_r <= pwdata[COUNT_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_STAGE_COUNT) begin
      prdata = {{(CFG_DATA_W-COUNT_BITS){1'b0}}, stage_count_r};
    end else begin
      prdata = {{(CFG_DATA_W-1){1'b0}}, interp_en_r};
    end
  end

  assign interp_en   = interp_en_r;
  assign stage_count = stage_count_r;

endmodule

// ===== src/sbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stage bracket interpolator controller
// Sequences acceptance, table scan, weight division and result hand-off.
// ----------------------------------------------------------------------------
module sbi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sbi_pkg::sts_t sts,
  output sbi_pkg::cmd_t cmd
);
  import sbi_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.in_query) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit || sts.at_last) begin
          state_nxt = sts.need_div ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_START: begin
        cmd.rd_first = 1'b1;
      end
      ST_SCAN: begin
        if (sts.hit || sts.at_last) begin
          cmd.take = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd.result_load = !sts.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/sbi_dpath.sv =====
// ----------------------------------------------------------------------------
// Stage bracket interpolator datapath
// Stage table memories, scan pointer, bit-serial weight divider, field cache
// bookkeeping and the output register.
// ----------------------------------------------------------------------------
module sbi_dpath #(
  parameter int STAGE_DEPTH = sbi_pkg::STAGE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sbi_pkg::in_item_t              in_data,
  input  sbi_pkg::cmd_t                  cmd,
  output sbi_pkg::sts_t                  sts,
  input  logic                           interp_en,
  input  logic [sbi_pkg::COUNT_BITS-1:0] stage_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sbi_pkg::out_item_t             out_data
);
  import sbi_pkg::*;

  localparam int IDX_W = $clog2(STAGE_DEPTH);

  // Stage table.
  logic [TIME_BITS-1:0] time_mem [STAGE_DEPTH];
  logic [FILE_BITS-1:0] file_mem [STAGE_DEPTH];
  logic [TIME_BITS-1:0] rd_time_r;
  logic [FILE_BITS-1:0] rd_file_r;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 wr_en;

  // Query and scan state.
  logic [TIME_BITS-1:0] t_r;
  logic [IDX_W-1:0]     last_r;
  logic [IDX_W-1:0]     last_nxt;
  logic [IDX_W-1:0]     idx_r;
  logic [TIME_BITS-1:0] prev_time_r;
  logic [FILE_BITS-1:0] prev_file_r;
  logic                 hit;
  logic                 at_last;
  logic                 bracket;

  // Bracket result.
  logic [IDX_W-1:0]     lo_r;
  logic [IDX_W-1:0]     up_r;
  logic [FILE_BITS-1:0] lo_file_r;
  logic [FILE_BITS-1:0] up_file_r;

  // Divider.
  logic [TIME_BITS-1:0]        rem_r;
  logic [TIME_BITS-1:0]        den_r;
  logic [WEIGHT_FRAC_BITS-1:0] q_r;
  logic [DIV_CNT_W-1:0]        cnt_r;
  logic [TIME_BITS-1:0]        diff;
  logic                        ge;
  logic [TIME_BITS-1:0]        rem_nxt;

  // Field cache.
  logic             lslot_v_r;
  logic             uslot_v_r;
  logic [IDX_W-1:0] lslot_r;
  logic [IDX_W-1:0] uslot_r;
  logic             lhit;
  logic             swap;
  logic             uv_mid;
  logic [IDX_W-1:0] us_mid;
  logic [1:0]       lact;
  logic [1:0]       uact;

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r;

  // Entries beyond the table depth are not stored.
  assign wr_en   = cmd.accept && (in_data.opcode == OP_WRITE)
                   && (int'(in_data.entry_index) < STAGE_DEPTH);
  assign wr_addr = IDX_W'(in_data.entry_index);
  assign rd_addr = cmd.rd_first ? idx_r : IDX_W'(idx_r + 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= in_data.time_value;
      file_mem[wr_addr] <= in_data.file_id;
    end
    rd_time_r <= time_mem[rd_addr];
    rd_file_r <= file_mem[rd_addr];
  end

  // Effective count is clamped to one through the table depth.
  always_comb begin
    if (stage_count == '0) begin
      last_nxt = '0;
    end else if (int'(stage_count) > STAGE_DEPTH) begin
      last_nxt = IDX_W'(STAGE_DEPTH - 1);
    end else begin
      last_nxt = IDX_W'(stage_count - 1'b1);
    end
  end

  assign hit     = t_r < rd_time_r;
  assign at_last = idx_r == last_r;
  assign bracket = hit && (idx_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r    <= in_data.time_value;
      last_r <= last_nxt;
      idx_r  <= '0;
    end else if (cmd.scan_step) begin
      idx_r       <= IDX_W'(idx_r + 1'b1);
      prev_time_r <= rd_time_r;
      prev_file_r <= rd_file_r;
    end
  end

  // A bracket has the previous entry as lower stage; otherwise the scan
  // stopped at the first entry or ran off the end, and both stages coincide.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      up_r      <= idx_r;
      up_file_r <= rd_file_r;
      if (bracket) begin
        lo_r      <= IDX_W'(idx_r - 1'b1);
        lo_file_r <= prev_file_r;
      end else begin
        lo_r      <= idx_r;
        lo_file_r <= rd_file_r;
      end
    end
  end

  // Restoring fraction divider, one quotient bit per cycle. The remainder
  // always stays below the divisor, so it never needs an extra bit.
  assign diff    = den_r - rem_r;
  assign ge      = rem_r >= diff;
  assign rem_nxt = ge ? (rem_r - diff) : {rem_r[TIME_BITS-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rem_r <= t_r - prev_time_r;
      den_r <= rd_time_r - prev_time_r;
      q_r   <= '0;
      cnt_r <= DIV_CNT_W'(WEIGHT_FRAC_BITS - 1);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[WEIGHT_FRAC_BITS-2:0], ge};
      cnt_r <= DIV_CNT_W'(cnt_r - 1'b1);
    end
  end

  // Slot decisions. After a swap the upper slot holds the old lower slot.
  assign lhit   = lslot_v_r && (lslot_r == lo_r);
  assign swap   = !lhit && uslot_v_r && (uslot_r == lo_r);
  assign uv_mid = swap ? lslot_v_r : uslot_v_r;
  assign us_mid = swap ? lslot_r : uslot_r;

  always_comb begin
    if (lhit) begin
      lact = LACT_KEEP;
    end else if (swap) begin
      lact = LACT_SWAP;
    end else begin
      lact = LACT_LOAD;
    end
    if (lo_r == up_r) begin
      uact = UACT_RELEASE;
    end else if (uv_mid && (us_mid == up_r)) begin
      uact = UACT_KEEP;
    end else begin
      uact = UACT_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lslot_v_r <= 1'b0;
      uslot_v_r <= 1'b0;
      lslot_r   <= '0;
      uslot_r   <= '0;
    end else if (cmd.result_load) begin
      lslot_v_r <= 1'b1;
      uslot_v_r <= lo_r != up_r;
      lslot_r   <= lo_r;
      uslot_r   <= up_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_data_r.lower_stage  <= INDEX_BITS'(lo_r);
      out_data_r.upper_stage  <= INDEX_BITS'(up_r);
      out_data_r.weight       <= {1'b0, q_r};
      out_data_r.lower_action <= lact;
      out_data_r.upper_action <= uact;
      out_data_r.lower_file   <= lo_file_r;
      out_data_r.upper_file   <= up_file_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The weight needs division only when interpolation is enabled, inside a true
  // bracket with the query strictly after the lower stage.
  assign sts.in_query = in_data.opcode == OP_QUERY;
  assign sts.hit      = hit;
  assign sts.at_last  = at_last;
  assign sts.need_div = bracket && interp_en && (t_r != prev_time_r);
  assign sts.div_last = cnt_r == '0;
  assign sts.out_busy = out_valid_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (idx_r != last_r))
    else $error("scan stepped past the last stage");

  a_adjacent_stages: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_load |-> ((up_r == lo_r) || (up_r == IDX_W'(lo_r + 1'b1))))
    else $error("bracketing stages are not adjacent");

  a_div_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < den_r))
    else $error("divider remainder reached the divisor");

  a_cache_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_load |=> (lslot_v_r && (uslot_v_r == $past(lo_r != up_r))))
    else $error("field cache slots inconsistent after a result");

endmodule

// ===== src/stage_bracket_interpolator.sv =====
// ----------------------------------------------------------------------------
// Stage bracket interpolator
// Stage time table with bracketing search, Q1.16 interpolation weight and
// two-slot field cache bookkeeping.
// ----------------------------------------------------------------------------
// A write beat (opcode write) stores one stage time and file number and is
// done in the cycle it is accepted. A query beat scans the table from entry
// 0, one entry per cycle through the single read port of the table memory,
// until it meets the first stage later than the queried time or reaches the
// last valid stage; when the query lies strictly inside a bracket and
// interpolation is enabled, a restoring divider then produces the weight one
// bit per cycle. From acceptance, a query passes the first table read, the
// scan and, when it runs, the divider, and its result is then loaded into
// the output register. The block handles one query at a time, but the
// result sits in an output register, so the next beat can be accepted while
// the previous result waits for out_ready. There is no clearing pass: table
// entries that were never written read back as unknown, and stage_count
// must cover only written entries.
// ----------------------------------------------------------------------------
module stage_bracket_interpolator #(
  parameter int STAGE_DEPTH = sbi_pkg::STAGE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sbi_pkg::in_item_t              in_data,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output sbi_pkg::out_item_t             out_data,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbi_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sbi_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sbi_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sbi_pkg::*;

  // Command and status bundles between the controller and the datapath.
  cmd_t                  cmd;
  sts_t                  sts;
  logic                  interp_en;
  logic [COUNT_BITS-1:0] stage_count;

  // Register file: interpolation enable at byte address 0, stage count at 4.
  sbi_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .interp_en   (interp_en),
    .stage_count (stage_count)
  );

  // The controller owns the sequence; it accepts a beat only when idle.
  sbi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the table, the scan, the divider, the cache slots and
  // the output register.
  sbi_dpath #(
    .STAGE_DEPTH (STAGE_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .interp_en   (interp_en),
    .stage_count (stage_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
